@@ hw/rtl/arc_pkg.sv @@
// arc_pkg: shared constants, codes and types for the arp cache resolver
// used by arc_cell and arp_cache_resolver_top; no dependencies
package arc_pkg;

    localparam int ENTRIES   = 16;
    localparam int IP_W      = 32;
    localparam int MAC_W     = 48;
    localparam int OPER_W    = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic             FUNC_LOOKUP  = 1'b0;
    localparam logic             FUNC_LEARN   = 1'b1;
    localparam logic [OPER_W-1:0] OPER_REQUEST = 16'd1;

    localparam logic [CFG_IDX_W-1:0] REG_OWN_IP      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SUBNET_MASK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GATEWAY_IP  = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic             write;
        logic [IP_W-1:0]  key;
        logic [MAC_W-1:0] mac;
        logic             any_match;
        logic             any_free;
    } cell_bcast_t;

    // handed from each cell to its right neighbor
    typedef struct packed {
        logic             head;
        logic             found;
        logic             free_seen;
        logic [MAC_W-1:0] mac;
    } cell_link_t;

endpackage

@@ hw/rtl/arp_cache_resolver_top.sv @@
// arp_cache_resolver_top: ip-to-mac table built as a row of arc_cell entries
// depends on arc_pkg and arc_cell
//
// Each transaction has an accept cycle, where the next-hop
// address and the reply flag are formed, and an execute cycle, in which the
// search key is broadcast to the row of cells, the first-match and first-free
// flags ripple from cell to cell, a learn writes its entry and the result is
// registered. The done strobe is registered from the execute cycle, and
// the result is held until a later execute cycle replaces it. Busy is already
// low while done is high, so a new start can be taken in that same cycle. The
// result cannot be held off. Configuration writes are taken at any time and take effect once registered.
module arp_cache_resolver_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [arc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [arc_pkg::IP_W-1:0]      cfg_data,
    input  logic                          start,
    output logic                          busy,
    input  logic                          func,
    input  logic [arc_pkg::IP_W-1:0]      ip_addr,
    input  logic [arc_pkg::MAC_W-1:0]     mac_addr,
    input  logic [arc_pkg::OPER_W-1:0]    arp_oper,
    input  logic [arc_pkg::IP_W-1:0]      arp_tpa,
    output logic                          done,
    output logic                          hit,
    output logic [arc_pkg::MAC_W-1:0]     mac_found,
    output logic [arc_pkg::IP_W-1:0]      next_hop_ip,
    output logic                          send_reply
);
    import arc_pkg::*;

    logic [IP_W-1:0] own_ip_reg;
    logic [IP_W-1:0] subnet_mask_reg;
    logic [IP_W-1:0] gateway_ip_reg;

    state_t state_reg;
    state_t state_next;

    logic accept;
    logic exec;

    logic             func_reg;
    logic [IP_W-1:0]  key_reg;
    logic [MAC_W-1:0] mac_in_reg;
    logic             reply_reg;

    logic [IP_W-1:0]  hop;
    logic             on_subnet;

    logic             done_reg;
    logic             hit_reg;
    logic [MAC_W-1:0] mac_found_reg;
    logic [IP_W-1:0]  next_hop_reg;
    logic             send_reply_reg;

    cell_bcast_t bcast;
    cell_link_t  links [ENTRIES+1];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_ip_reg      <= '0;
            subnet_mask_reg <= '0;
            gateway_ip_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_OWN_IP:      own_ip_reg      <= cfg_data;
                REG_SUBNET_MASK: subnet_mask_reg <= cfg_data;
                REG_GATEWAY_IP:  gateway_ip_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // control
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy = 1'b0;
        exec = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                exec = 1'b0;
            end
            ST_EXEC:
            begin
                busy = 1'b1;
                exec = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
                exec = 1'b0;
            end
        endcase
    end

    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= exec;
        end
    end

    // accept stage
    assign on_subnet = (ip_addr & subnet_mask_reg) == (own_ip_reg & subnet_mask_reg);
    assign hop       = (func == FUNC_LEARN || on_subnet) ? ip_addr : gateway_ip_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg   <= func;
            key_reg    <= hop;
            mac_in_reg <= mac_addr;
            reply_reg  <= (arp_oper == OPER_REQUEST) && (arp_tpa == own_ip_reg);
        end
    end

    // cell row
    assign links[0] = '{head: 1'b1, found: 1'b0, free_seen: 1'b0, mac: '0};

    always_comb
    begin
        bcast.write     = exec && (func_reg == FUNC_LEARN);
        bcast.key       = key_reg;
        bcast.mac       = mac_in_reg;
        bcast.any_match = links[ENTRIES].found;
        bcast.any_free  = links[ENTRIES].free_seen;
    end

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        arc_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .bcast    (bcast),
            .link_in  (links[i]),
            .link_out (links[i+1])
        );
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            if (func_reg == FUNC_LOOKUP)
            begin
                hit_reg        <= links[ENTRIES].found;
                mac_found_reg  <= links[ENTRIES].mac;
                next_hop_reg   <= key_reg;
                send_reply_reg <= 1'b0;
            end
            else
            begin
                hit_reg        <= 1'b0;
                mac_found_reg  <= '0;
                next_hop_reg   <= '0;
                send_reply_reg <= reply_reg;
            end
        end
    end

    assign done        = done_reg;
    assign hit         = hit_reg;
    assign mac_found   = mac_found_reg;
    assign next_hop_ip = next_hop_reg;
    assign send_reply  = send_reply_reg;

    // checks
    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_EXEC))
        else $error("done without an execute cycle");

    a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy && done)
        else $error("execute cycle did not complete in one cycle");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted transaction did not start");

    a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (done && send_reply) |-> (!hit && next_hop_ip == '0))
        else $error("learn result carries lookup fields");

endmodule

@@ hw/rtl/arc_cell.sv @@
// arc_cell: one table entry (ip, mac, valid) with its local compare and update
// depends on arc_pkg
module arc_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  arc_pkg::cell_bcast_t bcast,
    input  arc_pkg::cell_link_t  link_in,
    output arc_pkg::cell_link_t  link_out
);
    import arc_pkg::*;

    logic [IP_W-1:0]  ip_reg;
    logic [MAC_W-1:0] mac_reg;
    logic             valid_reg;

    logic match;
    logic take_update;
    logic take_fill;

    assign match       = valid_reg && (ip_reg == bcast.key);
    assign take_update = bcast.write && match && !link_in.found;
    assign take_fill   = bcast.write && !bcast.any_match &&
                         ((!valid_reg && !link_in.free_seen) ||
                          (!bcast.any_free && link_in.head));

    always_comb
    begin
        link_out.head      = 1'b0;
        link_out.found     = link_in.found || match;
        link_out.free_seen = link_in.free_seen || !valid_reg;
        if (link_in.found)
        begin
            link_out.mac = link_in.mac;
        end
        else if (match)
        begin
            link_out.mac = mac_reg;
        end
        else
        begin
            link_out.mac = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take_fill)
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_fill)
        begin
            ip_reg <= bcast.key;
        end
        if (take_fill || take_update)
        begin
            mac_reg <= bcast.mac;
        end
    end

endmodule
